>>> rtl/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared constants, codes and types of the button macro recorder.
// ----------------------------------------------------------------------------
package bmr_pkg;

  // pin and field widths
  localparam int PIN_W  = 6;
  localparam int IDX_W  = 8;
  localparam int MODE_W = 3;
  localparam int CFG_W  = 8;

  // sample store geometry
  localparam int STORE_DEPTH = 128;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam logic [IDX_W-1:0] STORE_DEPTH_IDX = IDX_W'(STORE_DEPTH);

  // pin assignment: five buttons and the record/play pin
  localparam logic [PIN_W-1:0] BUTTON_MASK = 6'h37;
  localparam int               RP_BIT      = 3;

  // item kinds
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_CHANGE = 1'b1;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RECORD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PLAY     = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 8'd20;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 8'd10;

  // current configuration
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] step_interval;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [PIN_W-1:0]  tristate_mask;
    logic [PIN_W-1:0]  drive_level;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  recorded_length;
  } result_t;

endpackage

>>> rtl/bmr_if.sv
// ----------------------------------------------------------------------------
// bmr_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface bmr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [5:0] pin_levels;

  modport source (output valid, output func, output pin_levels, input ready);
  modport sink   (input valid, input func, input pin_levels, output ready);
endinterface

interface bmr_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] tristate_mask;
  logic [5:0] drive_level;
  logic [2:0] mode;
  logic [7:0] recorded_length;

  modport source (output valid, output tristate_mask, output drive_level, output mode,
                  output recorded_length, input ready);
  modport sink   (input valid, input tristate_mask, input drive_level, input mode,
                  input recorded_length, output ready);
endinterface

>>> rtl/bmr_ram.sv
// ----------------------------------------------------------------------------
// bmr_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bmr_cfg.sv
// ----------------------------------------------------------------------------
// bmr_cfg
// Configuration registers: debounce length and sample interval.
// ----------------------------------------------------------------------------
module bmr_cfg import bmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [CFG_W-1:0] debounce_q;
  logic [CFG_W-1:0] interval_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.debounce_ticks = debounce_q;
  assign cfg_o.step_interval  = interval_q;

endmodule

>>> rtl/bmr_fsm.sv
// ----------------------------------------------------------------------------
// bmr_fsm
// Mode sequencer: debounce, wait, record and playback, with the sample store.
// ----------------------------------------------------------------------------
module bmr_fsm import bmr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             func_i,
  input  logic [PIN_W-1:0] pins_i,
  input  cfg_t             cfg_i,
  output result_t          result_o
);

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [IDX_W-1:0]  tick_q, tick_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  len_q, len_d;
  logic [PIN_W-1:0]  tri_q, tri_d;
  logic [PIN_W-1:0]  lvl_q, lvl_d;

  logic                held;
  logic [IDX_W-1:0]    tick_inc;
  logic [IDX_W-1:0]    idx_inc;
  logic                st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [PIN_W-1:0]    st_rdata;

  assign held     = ~pins_i[RP_BIT];
  assign tick_inc = tick_q + IDX_W'(1);
  assign idx_inc  = idx_q + IDX_W'(1);

  // next state for one item
  always_comb begin
    mode_d   = mode_q;
    tick_d   = tick_q;
    idx_d    = idx_q;
    len_d    = len_q;
    tri_d    = tri_q;
    lvl_d    = lvl_q;
    st_we    = 1'b0;
    st_waddr = idx_q[STORE_AW-1:0];
    if (accept_i) begin
      if (func_i == FUNC_CHANGE) begin
        // change event only arms the debounce from idle
        if (mode_q == MODE_IDLE) begin
          mode_d = MODE_DEBOUNCE;
          tick_d = '0;
        end
      end else begin
        case (mode_q)
          MODE_DEBOUNCE: begin
            lvl_d = pins_i;
            if (held) begin
              tick_d = tick_inc;
              if (tick_inc >= cfg_i.debounce_ticks) begin
                tri_d  = BUTTON_MASK;
                mode_d = MODE_WAIT;
              end
            end else begin
              tri_d  = BUTTON_MASK;
              mode_d = MODE_IDLE;
            end
          end
          MODE_WAIT: begin
            lvl_d = pins_i;
            if (held) begin
              // any button pressed starts recording with the first sample
              if ((~pins_i & BUTTON_MASK) != '0) begin
                tick_d   = '0;
                st_we    = 1'b1;
                st_waddr = '0;
                idx_d    = IDX_W'(1);
                mode_d   = MODE_RECORD;
              end
            end else begin
              tick_d = '0;
              idx_d  = '0;
              mode_d = MODE_PLAY;
            end
          end
          MODE_RECORD: begin
            lvl_d = pins_i;
            if (held) begin
              tick_d = tick_inc;
              if (tick_inc == cfg_i.step_interval) begin
                tick_d = '0;
                st_we  = (idx_q < STORE_DEPTH_IDX);
                idx_d  = idx_inc;
                // store full
                if (idx_inc >= STORE_DEPTH_IDX) begin
                  len_d  = idx_inc;
                  tri_d  = BUTTON_MASK;
                  mode_d = MODE_IDLE;
                end
              end
            end else begin
              len_d  = idx_q;
              tri_d  = BUTTON_MASK;
              mode_d = MODE_IDLE;
            end
          end
          MODE_PLAY: begin
            tick_d = tick_inc;
            if (tick_inc == cfg_i.step_interval) begin
              tick_d = '0;
              if ((idx_q >= len_q) || (idx_q >= STORE_DEPTH_IDX)) begin
                tri_d  = BUTTON_MASK;
                mode_d = MODE_IDLE;
              end else begin
                // drive pressed buttons low, release the rest
                tri_d = st_rdata & BUTTON_MASK;
                lvl_d = st_rdata & BUTTON_MASK;
                idx_d = idx_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      tick_q <= '0;
      idx_q  <= '0;
      len_q  <= '0;
      tri_q  <= BUTTON_MASK;
      lvl_q  <= '0;
    end else begin
      mode_q <= mode_d;
      tick_q <= tick_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
      tri_q  <= tri_d;
      lvl_q  <= lvl_d;
    end
  end

  // sample store, read address follows the next index so the entry is ready
  bmr_ram #(
    .WIDTH (PIN_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (pins_i),
    .raddr_i (idx_d[STORE_AW-1:0]),
    .rdata_o (st_rdata)
  );

  // result as seen after this item
  assign result_o.tristate_mask   = tri_d;
  assign result_o.drive_level     = lvl_d & BUTTON_MASK;
  assign result_o.mode            = mode_d;
  assign result_o.recorded_length = len_d;

endmodule

>>> rtl/button_macro_recorder_core.sv
// ----------------------------------------------------------------------------
// button_macro_recorder_core
// Records and replays patterns of five active-low buttons under control of a
// record/play pin.
// ----------------------------------------------------------------------------
// Every accepted item (timer tick or record/play change event) yields exactly
// one result item, registered and valid in the next cycle. A new item is taken
// every clock cycle as long as the result register is empty or being drained
// in the same cycle, so the sustained rate is one item per cycle; it is set by
// the single mode/state register update per item. The 128-entry sample store
// is a RAM with registered read whose address tracks the next playback index,
// so an entry is always read out before the tick that replays it. The store
// needs no clearing after reset. Configuration writes should be made while no
// result is pending.
module button_macro_recorder_core import bmr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bmr_in_if.sink               in_chan,
  bmr_out_if.source            out_chan
);

  cfg_t    cfg;
  result_t result_d;
  result_t result_q;
  logic    out_valid_q;
  logic    accept;

  // take an item whenever the result register is free or being emptied
  assign in_chan.ready = ~out_valid_q | out_chan.ready;
  assign accept        = in_chan.valid & in_chan.ready;

  // configuration registers
  bmr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // mode sequencer and sample store
  bmr_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (in_chan.func),
    .pins_i   (in_chan.pin_levels),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_chan.valid           = out_valid_q;
  assign out_chan.tristate_mask   = result_q.tristate_mask;
  assign out_chan.drive_level     = result_q.drive_level;
  assign out_chan.mode            = result_q.mode;
  assign out_chan.recorded_length = result_q.recorded_length;

endmodule
